// File: hw/rtl/fifo_with_ordered_insert_macros.svh
// Assertion macros for the ordered-insert queue checker.
// Depends on nothing; included by the checker file.
`ifndef FIFO_WITH_ORDERED_INSERT_MACROS_SVH
`define FIFO_WITH_ORDERED_INSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define FWOI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define FWOI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fwoi_pkg.sv
// Shared types and constants of the ordered-insert queue.
// Depends on nothing; imported by every module of the block.
package fwoi_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned OCC_W = 5;

  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_DEQ = 2'd1;
  localparam logic [1:0] MODE_INS = 2'd2;

  localparam logic signed [VAL_W-1:0] NO_VALUE = -32'sd1;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic                    out_valid;
    logic                    empty_error;
    logic                    full_error;
    logic [OCC_W-1:0]        occupancy;
  } res_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// File: hw/rtl/fwoi_ctrl.sv
// Sequencer of the ordered-insert queue: capture a word, then run the cell update.
// Depends on fwoi_pkg.
module fwoi_ctrl
  import fwoi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o        = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = start_i;
      end
      ST_EXEC: begin
        busy_o        = 1'b1;
        cmd_o.execute = 1'b1;
      end
      default: busy_o = 1'b0;
    endcase
  end

endmodule

// File: hw/rtl/fwoi_datapath.sv
// Shifting cell array, entry count and result register of the ordered-insert queue.
// Depends on fwoi_pkg.
module fwoi_datapath
  import fwoi_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t req_i,
  output res_t res_o,
  output logic res_valid_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [VAL_W-1:0] cell_q [DEPTH];
  logic signed [VAL_W-1:0] cell_d [DEPTH];
  logic [CW-1:0]           count_q, count_d;
  req_t                    req_q;
  res_t                    res_q, res_d;
  logic                    res_valid_q;

  logic [DEPTH-1:0] sel;
  logic [DEPTH-1:0] ahead;
  logic [DEPTH-1:0] low_mask;
  logic             full;
  logic             empty;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    // Per-cell insert point flags; first flagged cell takes the new value.
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i) < count_q) begin
        if (i == 0) sel[i] = (cell_q[i] > req_q.value);
        else        sel[i] = (cell_q[i] >= req_q.value);
      end else begin
        sel[i] = (CW'(i) == count_q);
      end
      if (req_q.mode == MODE_ENQ) sel[i] = (CW'(i) == count_q);
    end
    for (int i = 0; i < DEPTH; i++) begin
      low_mask = (DEPTH'(1) << i) - DEPTH'(1);
      ahead[i] = |(sel & low_mask);
    end
  end

  always_comb begin
    cell_d  = cell_q;
    count_d = count_q;
    res_d.out_value   = NO_VALUE;
    res_d.out_valid   = 1'b0;
    res_d.empty_error = 1'b0;
    res_d.full_error  = 1'b0;
    case (req_q.mode)
      MODE_ENQ, MODE_INS: begin
        if (full) begin
          res_d.full_error = 1'b1;
        end else begin
          count_d = count_q + CW'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (ahead[i]) begin
              if (i > 0) cell_d[i] = cell_q[i-1];
            end else if (sel[i]) begin
              cell_d[i] = req_q.value;
            end
          end
        end
      end
      MODE_DEQ: begin
        if (empty) begin
          res_d.empty_error = 1'b1;
        end else begin
          res_d.out_value = cell_q[0];
          res_d.out_valid = 1'b1;
          count_d         = count_q - CW'(1);
          for (int i = 0; i < DEPTH - 1; i++) begin
            cell_d[i] = cell_q[i+1];
          end
        end
      end
      default: ;
    endcase
    res_d.occupancy = OCC_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.execute;
      if (cmd_i.execute) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    if (cmd_i.execute) begin
      cell_q <= cell_d;
      res_q  <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

// File: hw/rtl/fifo_with_ordered_insert.sv
// Top level of the bounded queue with enqueue, dequeue and ordered insert.
// Depends on fwoi_pkg, fwoi_ctrl and fwoi_datapath.
//
// A word is captured at the edge that sees start high with busy low; the
// following cycle (busy high) runs the update of the shifting cell array,
// where for an insert every cell compares its entry against the value at
// once and the first matching cell takes the new value while the cells
// behind it shift one place toward the tail. res_valid_o is high for exactly
// one cycle, the cycle after busy, to mark the result on res_o; busy is
// already low then, so the next word may be started while a result shows.
// The receiver cannot stall: sample res_o whenever res_valid_o is high, as it
// is never repeated. Every operation yields one result, including the unused
// mode code (no change, no flags). Entries need no clearing after reset; the
// block takes its first word right after reset is released.
module fifo_with_ordered_insert
  import fwoi_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output res_t res_o,
  output logic res_valid_o
);

  cmd_t cmd;

  // Sequence: hold off new words while the cell update runs.
  fwoi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // Store, shift and compare entries; register the result word.
  fwoi_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

// File: hw/rtl/fwoi_checker.sv
// Port-level checks of the ordered-insert queue, bound to the top level.
// Depends on fwoi_pkg and fifo_with_ordered_insert_macros.svh.
`include "fifo_with_ordered_insert_macros.svh"

module fwoi_checker
  import fwoi_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input res_t res_o,
  input logic res_valid_o
);

  `FWOI_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted word did not raise busy")
  `FWOI_ASSERT_NEXT(a_busy_result, clk_i, rst_ni, busy, res_valid_o && !busy, "busy cycle gave no result")
  `FWOI_ASSERT_NOW(a_flags_excl, clk_i, rst_ni, res_valid_o, $onehot0({res_o.out_valid, res_o.empty_error, res_o.full_error}), "result flags not exclusive")
  `FWOI_ASSERT_NOW(a_no_value, clk_i, rst_ni, res_valid_o && !res_o.out_valid, res_o.out_value == NO_VALUE, "missing value not all ones")

endmodule

bind fifo_with_ordered_insert fwoi_checker u_fwoi_checker (.*);

// File: test/fwoi_checker.sv
// Checker for the ordered-insert queue: predicts each word's result, compares.
// Depends on fwoi_pkg; instantiated by tb beside the block.
module fwoi_tb_checker
  import fwoi_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  res_t        res_i,
  input  logic        res_valid_i,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [VAL_W-1:0] shadow [DEPTH];
  int unsigned             shadow_count = 0;
  res_t                    due_results [$];

  // Apply one word to the shadow queue and return the result it should give.
  function automatic res_t queue_op(req_t w);
    res_t                    r;
    logic signed [VAL_W-1:0] v;
    int unsigned             pos;
    int unsigned             i;
    v             = w.value;
    r.out_value   = NO_VALUE;
    r.out_valid   = 1'b0;
    r.empty_error = 1'b0;
    r.full_error  = 1'b0;
    case (w.mode)
      MODE_ENQ, MODE_INS: begin
        if (shadow_count >= DEPTH) begin
          r.full_error = 1'b1;
        end else begin
          pos = shadow_count;
          if (w.mode == MODE_INS && shadow_count != 0) begin
            // head is passed over on a tie, later entries stop on a tie
            if (shadow[0] > v) begin
              pos = 0;
            end else begin
              pos = 1;
              while (pos < shadow_count && v > shadow[pos]) pos++;
            end
          end
          for (i = shadow_count; i > pos; i--) shadow[i] = shadow[i-1];
          shadow[pos] = v;
          shadow_count++;
        end
      end
      MODE_DEQ: begin
        if (shadow_count == 0) begin
          r.empty_error = 1'b1;
        end else begin
          r.out_value = shadow[0];
          r.out_valid = 1'b1;
          for (i = 1; i < shadow_count; i++) shadow[i-1] = shadow[i];
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  task automatic flag(input string what, input res_t want, input res_t got);
    mismatches_o++;
    if (mismatches_o <= 10)
      $display({"checker: %s: want val %0d vld %b emp %b full %b occ %0d, ",
                "got val %0d vld %b emp %b full %b occ %0d"},
               what, want.out_value, want.out_valid, want.empty_error, want.full_error,
               want.occupancy, got.out_value, got.out_valid, got.empty_error,
               got.full_error, got.occupancy);
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      due_results.delete();
      pending_o    = 0;
      mismatches_o = 0;
    end else begin
      // results belong to earlier words, so check before taking a new one
      if (res_valid_i) begin
        if (due_results.size() == 0) begin
          flag("result with nothing pending", '0, res_i);
        end else begin
          want = due_results.pop_front();
          if (res_i.out_value !== want.out_value || res_i.out_valid !== want.out_valid ||
              res_i.empty_error !== want.empty_error ||
              res_i.full_error !== want.full_error || res_i.occupancy !== want.occupancy)
            flag("mismatch", want, res_i);
        end
      end
      if (start_i && !busy_i) due_results.push_back(queue_op(req_i));
      pending_o = due_results.size();
    end
  end

endmodule

// File: test/tb.sv
// Testbench top for the ordered-insert queue: drives words, gives the verdict.
// Depends on fwoi_pkg, fifo_with_ordered_insert and fwoi_tb_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fwoi_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned RAND_WORDS  = 550;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  res_t        res_o;
  logic        res_valid_o;
  int unsigned pending;
  int unsigned mismatches;

  // When set, words go back to back with no gaps at all.
  bit          burst = 1'b0;

  fifo_with_ordered_insert #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  // The checker sees the same ports and owns all prediction and comparison.
  fwoi_tb_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .res_i       (res_o),
    .res_valid_i (res_valid_o),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest correct run (about 600 words with the longest gap each).
  initial begin
    #400000;
    $display("tb: done, errors");
    $finish;
  end

  // Values: extremes, a narrow band around zero so ties are common, or any.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3, 4: return int'($urandom_range(0, 8)) - 4;
      default: return $urandom();
    endcase
  endfunction

  // Gaps: mostly none or short, a few long; none at all while bursting.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold start low for the gap, present the word at a falling edge, then
  // wait for the rising edge that takes it (start high, busy low).
  task automatic send_word(input logic [1:0] mode, input logic signed [VAL_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start       <= 1'b1;
    req_i.mode  <= mode;
    req_i.value <= value;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    int unsigned sent;
    int unsigned run_len;
    int unsigned fill_pct;
    int unsigned r;
    logic [1:0]  mode;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty dequeue, insert into empty, head tie passed over,
    // insert ahead of a larger head, tie with a later entry, extremes,
    // the unused mode code, then fill up and hit the full queue both ways.
    send_word(MODE_DEQ, VAL_MAX);
    send_word(MODE_INS, 32'sd5);
    send_word(MODE_INS, 32'sd5);
    send_word(MODE_INS, 32'sd3);
    send_word(MODE_INS, 32'sd5);
    send_word(MODE_ENQ, VAL_MAX);
    send_word(MODE_ENQ, VAL_MIN);
    send_word(MODE_INS, VAL_MIN);
    send_word(MODE_INS, VAL_MAX);
    send_word(MODE_UNUSED, -32'sd1);
    send_word(MODE_INS, 32'sd0);
    send_word(MODE_INS, -32'sd1);
    for (int i = 0; i < 6; i++) send_word(MODE_ENQ, pick_value());
    // Queue now holds DEPTH entries.
    send_word(MODE_ENQ, 32'sd7);
    send_word(MODE_INS, 32'sd4);
    send_word(MODE_DEQ, 32'sd0);
    send_word(MODE_DEQ, VAL_MIN);
    send_word(MODE_UNUSED, VAL_MAX);
    send_word(MODE_DEQ, pick_value());

    // Random: runs that lean toward filling, draining or neither, so the
    // queue keeps crossing between empty and full with random content.
    sent = 0;
    while (sent < RAND_WORDS) begin
      run_len = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0: fill_pct = 80;
        1: fill_pct = 20;
        default: fill_pct = 50;
      endcase
      burst = ($urandom_range(0, 3) == 0);
      repeat (run_len) begin
        r = $urandom_range(0, 99);
        if (r < 3)
          mode = MODE_UNUSED;
        else if (r < 3 + fill_pct)
          mode = ($urandom_range(0, 9) < 6) ? MODE_INS : MODE_ENQ;
        else
          mode = MODE_DEQ;
        send_word(mode, pick_value());
        sent++;
      end
    end

    // Drop start, drain what is still pending, then wait for any stray
    // result before the verdict.
    @(negedge clk_i);
    start <= 1'b0;
    wait (pending == 0);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/fwoi_pkg.sv
hw/rtl/fwoi_ctrl.sv
hw/rtl/fwoi_datapath.sv
hw/rtl/fifo_with_ordered_insert.sv
hw/rtl/fwoi_checker.sv
test/fwoi_checker.sv
test/tb.sv
